/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the tilt fusion block.
// Each macro expands to one labeled concurrent assertion on a clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/iftf_pkg.sv */
// Shared types, constants and helper functions of the tilt fusion block.
// Used by iftf_cordic and imu_fifo_tilt_fusion; depends on nothing.
package iftf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int TABLE_FRAC       = 24;
    localparam int TABLE_LEN        = 24;

    localparam logic [19:0] GYRO_SCALE_RST  = 20'd157541;
    localparam logic [19:0] ACCEL_SCALE_RST = 20'd262152;
    localparam logic [15:0] BLEND_WT_RST    = 16'd63570;

    localparam logic [2:0] CMD_RUN_START = 3'd0;
    localparam logic [2:0] CMD_SAMPLE    = 3'd1;
    localparam logic [2:0] CMD_RUN_END   = 3'd2;
    localparam logic [2:0] CMD_CAL_START = 3'd3;
    localparam logic [2:0] CMD_CAL_END   = 3'd4;

    localparam logic [1:0] REG_GYRO_SCALE  = 2'd0;
    localparam logic [1:0] REG_ACCEL_SCALE = 2'd1;
    localparam logic [1:0] REG_BLEND_WT    = 2'd2;

    localparam logic [2:0] CH_ACCEL_X = 3'd3;
    localparam logic [2:0] CH_NONE    = 3'd7;
    localparam logic [3:0] SLOT_LAST  = 4'd14;

    typedef struct packed {
        logic               start;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_cordic_req;

    function automatic logic [2:0] slot_chan(input logic [3:0] slot);
        logic [2:0] ch;
        case (slot)
            4'd0, 4'd6, 4'd9, 4'd12:  ch = 3'd0;
            4'd1, 4'd7, 4'd10, 4'd13: ch = 3'd1;
            4'd2, 4'd8, 4'd11, 4'd14: ch = 3'd2;
            4'd3:                     ch = 3'd3;
            4'd4:                     ch = 3'd4;
            4'd5:                     ch = 3'd5;
            default:                  ch = CH_NONE;
        endcase
        return ch;
    endfunction

    // atan(2^-i) in degrees, Q.24
    function automatic logic [31:0] atan_q24(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd754974720;
            5'd1:    v = 32'd445687602;
            5'd2:    v = 32'd235489088;
            5'd3:    v = 32'd119537938;
            5'd4:    v = 32'd60000934;
            5'd5:    v = 32'd30029717;
            5'd6:    v = 32'd15018523;
            5'd7:    v = 32'd7509720;
            5'd8:    v = 32'd3754917;
            5'd9:    v = 32'd1877466;
            5'd10:   v = 32'd938734;
            5'd11:   v = 32'd469367;
            5'd12:   v = 32'd234684;
            5'd13:   v = 32'd117342;
            5'd14:   v = 32'd58671;
            5'd15:   v = 32'd29335;
            5'd16:   v = 32'd14668;
            5'd17:   v = 32'd7334;
            5'd18:   v = 32'd3667;
            5'd19:   v = 32'd1833;
            5'd20:   v = 32'd917;
            5'd21:   v = 32'd458;
            5'd22:   v = 32'd229;
            5'd23:   v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/imu_fifo_tilt_fusion.sv */
// Tilt fusion block: routes sensor FIFO words to gyro/accel channels, calibrates,
// and blends gyro and CORDIC accel tilt. Uses iftf_pkg, iftf_cordic, assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per request:
//   start run batch, sample word, finish run batch, start or finish calibration.
//   o_in_stall is high while a request is in work. Start, finish-calibration and
//   skipped-slot requests are handled without stalling; a sample word makes one pass
//   through the shared multiplier, then the channel update.
//   Finish run batch (outside calibration) runs the CORDIC twice, once per axis,
//   and the shared multiplier twice per axis.
//   It yields one result on the output channel (o_out_valid / i_out_stall).
//   The result sits in an output register; while the receiver stalls it holds,
//   and the block keeps taking requests until a second result is ready, which
//   then waits in the sequencer.
//   Configuration registers must be written over the APB port only while idle;
//   the block does not enforce this. Synchronous reset restores the register defaults
//   and clears all offsets, sums, tilt angles, the slot counter and the fault flag.
`include "assert_macros.svh"

module imu_fifo_tilt_fusion #(
    parameter int CORDIC_STEPS = iftf_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = iftf_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_command,
    input  logic signed [15:0] i_sample,
    input  logic [3:0]         i_start_slot,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_tilt_x,
    output logic signed [31:0] o_tilt_y,
    output logic signed [31:0] o_rate_sum_x,
    output logic signed [31:0] o_rate_sum_z,
    output logic signed [31:0] o_accel_x_out,
    output logic signed [31:0] o_accel_y_out,
    output logic signed [31:0] o_accel_z_out,
    output logic               o_slot_fault,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ANG_W = FRAC_BITS + 10;
    localparam int MA_W  = 35;
    localparam int MB_W  = 21;
    localparam int PR_W  = MA_W + MB_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_ACC, S_ATAN_GO, S_ATAN_WAIT,
        S_MUL_G, S_MUL_A, S_BLEND, S_PUSH
    } t_state;

    t_state r_state;

    logic [19:0] r_gscale, r_ascale;
    logic [15:0] r_wt;

    logic        r_cal, r_fault, r_axis;
    logic [3:0]  r_slot;
    logic signed [31:0] r_gsum [3];
    logic signed [31:0] r_aval [3];
    logic signed [31:0] r_goff [3];
    logic signed [31:0] r_aoff [3];
    logic signed [31:0] r_tilt [2];

    logic signed [15:0]      r_raw;
    logic [2:0]              r_ch;
    logic signed [PR_W-1:0]  r_prod;
    logic signed [63:0]      r_acc;
    logic signed [ANG_W-1:0] r_ang;

    logic        r_out_valid;
    logic signed [31:0] r_o_tx, r_o_ty, r_o_sx, r_o_sz, r_o_ax, r_o_ay, r_o_az;
    logic        r_o_fault;

    logic signed [MA_W-1:0]  w_mul_a;
    logic signed [MB_W-1:0]  w_mul_b;
    logic signed [PR_W-1:0]  w_mul_p;
    logic signed [32:0]      w_gpath;
    logic signed [63:0]      w_inc, w_blend;
    logic [1:0]              w_gidx, w_aidx;
    logic [2:0]              w_ch_in;
    logic                    w_acc_in, w_cfg_wr, w_cdone;
    logic signed [ANG_W-1:0] w_cang;
    iftf_pkg::t_cordic_req   w_creq;

    assign w_acc_in = i_in_valid && (r_state == S_IDLE);
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_ch_in  = iftf_pkg::slot_chan(r_slot);
    assign w_gidx   = r_ch[1:0];
    assign w_aidx   = 2'(r_ch - iftf_pkg::CH_ACCEL_X);

    assign w_gpath = r_axis ? ({r_tilt[1][31], r_tilt[1]} - {r_gsum[1][31], r_gsum[1]})
                            : ({r_tilt[0][31], r_tilt[0]} + {r_gsum[0][31], r_gsum[0]});

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SCALE: begin
                w_mul_a = {{(MA_W-16){r_raw[15]}}, r_raw};
                w_mul_b = {1'b0, (r_ch < iftf_pkg::CH_ACCEL_X) ? r_gscale : r_ascale};
            end
            S_MUL_G: begin
                w_mul_a = {{(MA_W-33){w_gpath[32]}}, w_gpath};
                w_mul_b = {5'd0, r_wt};
            end
            S_MUL_A: begin
                w_mul_a = {{(MA_W-ANG_W){r_ang[ANG_W-1]}}, r_ang};
                w_mul_b = MB_W'(17'h10000 - {1'b0, r_wt});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // round half up from Q.32 to Q.FRAC_BITS
    assign w_inc   = ($signed({{(64-PR_W){r_prod[PR_W-1]}}, r_prod})
                     + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    assign w_blend = (r_acc + $signed({{(64-PR_W){r_prod[PR_W-1]}}, r_prod})) >>> 16;

    always_comb begin
        w_creq.start = (r_state == S_ATAN_GO);
        w_creq.y     = r_axis ? r_aval[0] : r_aval[1];
        w_creq.x     = r_aval[2];
    end

    iftf_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_creq),
        .o_done  (w_cdone),
        .o_angle (w_cang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gscale    <= iftf_pkg::GYRO_SCALE_RST;
            r_ascale    <= iftf_pkg::ACCEL_SCALE_RST;
            r_wt        <= iftf_pkg::BLEND_WT_RST;
            r_cal       <= 1'b0;
            r_fault     <= 1'b0;
            r_axis      <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_gsum[k] <= '0;
                r_aval[k] <= '0;
                r_goff[k] <= '0;
                r_aoff[k] <= '0;
            end
            r_tilt[0] <= '0;
            r_tilt[1] <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    iftf_pkg::REG_GYRO_SCALE:  r_gscale <= pwdata[19:0];
                    iftf_pkg::REG_ACCEL_SCALE: r_ascale <= pwdata[19:0];
                    iftf_pkg::REG_BLEND_WT:    r_wt     <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        case (i_command)
                            iftf_pkg::CMD_RUN_START, iftf_pkg::CMD_CAL_START: begin
                                r_cal   <= (i_command == iftf_pkg::CMD_CAL_START);
                                r_slot  <= i_start_slot;
                                r_fault <= (i_start_slot > iftf_pkg::SLOT_LAST);
                                for (int k = 0; k < 3; k++) begin
                                    if (i_command == iftf_pkg::CMD_RUN_START) begin
                                        r_gsum[k] <= '0;
                                        r_aval[k] <= '0;
                                    end else begin
                                        r_goff[k] <= '0;
                                        r_aoff[k] <= '0;
                                    end
                                end
                            end
                            iftf_pkg::CMD_SAMPLE: begin
                                r_raw  <= i_sample;
                                r_ch   <= w_ch_in;
                                r_slot <= (r_slot < iftf_pkg::SLOT_LAST) ? r_slot + 4'd1 : 4'd0;
                                if (w_ch_in != iftf_pkg::CH_NONE) begin
                                    r_state <= S_SCALE;
                                end
                            end
                            iftf_pkg::CMD_CAL_END: begin
                                if (r_cal) begin
                                    for (int k = 0; k < 3; k++) begin
                                        r_goff[k] <= r_goff[k] >>> 2;
                                    end
                                    r_aoff[2] <= iftf_pkg::sat32((64'sd1 <<< FRAC_BITS)
                                                 - {{32{r_aoff[2][31]}}, r_aoff[2]});
                                    r_cal <= 1'b0;
                                end
                            end
                            iftf_pkg::CMD_RUN_END: begin
                                if (!r_cal) begin
                                    r_axis  <= 1'b0;
                                    r_state <= S_ATAN_GO;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCALE: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_ch < iftf_pkg::CH_ACCEL_X) begin
                        if (r_cal) begin
                            r_goff[w_gidx] <= iftf_pkg::sat32(w_inc
                                + {{32{r_goff[w_gidx][31]}}, r_goff[w_gidx]});
                        end else begin
                            r_gsum[w_gidx] <= iftf_pkg::sat32(w_inc
                                + {{32{r_gsum[w_gidx][31]}}, r_gsum[w_gidx]}
                                - {{32{r_goff[w_gidx][31]}}, r_goff[w_gidx]});
                        end
                    end else begin
                        if (r_cal) begin
                            r_aoff[w_aidx] <= iftf_pkg::sat32(w_inc);
                        end else begin
                            r_aval[w_aidx] <= iftf_pkg::sat32(w_inc
                                - {{32{r_aoff[w_aidx][31]}}, r_aoff[w_aidx]});
                        end
                    end
                    r_state <= S_IDLE;
                end
                S_ATAN_GO: begin
                    r_state <= S_ATAN_WAIT;
                end
                S_ATAN_WAIT: begin
                    if (w_cdone) begin
                        r_ang   <= w_cang;
                        r_state <= S_MUL_G;
                    end
                end
                S_MUL_G: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_MUL_A;
                end
                S_MUL_A: begin
                    r_acc   <= {{(64-PR_W){r_prod[PR_W-1]}}, r_prod} + 64'sd32768;
                    r_prod  <= w_mul_p;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    r_tilt[r_axis] <= iftf_pkg::sat32(w_blend);
                    if (r_axis) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_axis  <= 1'b1;
                        r_state <= S_ATAN_GO;
                    end
                end
                S_PUSH: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_tx      <= r_tilt[0];
                        r_o_ty      <= r_tilt[1];
                        r_o_sx      <= r_gsum[0];
                        r_o_sz      <= r_gsum[2];
                        r_o_ax      <= r_aval[0];
                        r_o_ay      <= r_aval[1];
                        r_o_az      <= r_aval[2];
                        r_o_fault   <= r_fault;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            iftf_pkg::REG_GYRO_SCALE:  prdata = {12'd0, r_gscale};
            iftf_pkg::REG_ACCEL_SCALE: prdata = {12'd0, r_ascale};
            iftf_pkg::REG_BLEND_WT:    prdata = {16'd0, r_wt};
            default:                   prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_tilt_x      = r_o_tx;
    assign o_tilt_y      = r_o_ty;
    assign o_rate_sum_x  = r_o_sx;
    assign o_rate_sum_z  = r_o_sz;
    assign o_accel_x_out = r_o_ax;
    assign o_accel_y_out = r_o_ay;
    assign o_accel_z_out = r_o_az;
    assign o_slot_fault  = r_o_fault;

    `CHK_NEXT(a_wait_to_mul, i_clk, i_rst_n, (r_state == S_ATAN_WAIT) && w_cdone, r_state == S_MUL_G, "CORDIC result not taken")
    `CHK_NEXT(a_push_fills, i_clk, i_rst_n, (r_state == S_PUSH) && !(r_out_valid && i_out_stall), r_out_valid && (r_state == S_IDLE), "result not pushed")
    `CHK_SAME(a_done_in_wait, i_clk, i_rst_n, w_cdone, r_state == S_ATAN_WAIT, "CORDIC done outside wait")

endmodule

/* rtl/core/iftf_cordic.sv */
// Iterative vectoring CORDIC: atan2(y, x) in degrees, one rotation per cycle.
// Uses iftf_pkg (request struct, arctangent table) and assert_macros.svh.
`include "assert_macros.svh"

module iftf_cordic #(
    parameter int CORDIC_STEPS = iftf_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = iftf_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iftf_pkg::t_cordic_req         i_req,
    output logic                          o_done,
    output logic signed [FRAC_BITS+9:0]   o_angle
);

    localparam int ANG_W = FRAC_BITS + 10;
    localparam int XW    = 35;
    localparam int IW    = $clog2(CORDIC_STEPS);
    localparam int SH    = iftf_pkg::TABLE_FRAC - FRAC_BITS;
    localparam logic signed [ANG_W-1:0] K180 = ANG_W'(180) << FRAC_BITS;

    logic                    r_busy, r_done, r_zero;
    logic [IW-1:0]           r_i;
    logic signed [XW-1:0]    r_x, r_y;
    logic signed [ANG_W-1:0] r_z;

    logic signed [XW-1:0]    w_xe, w_ye, w_dx, w_dy;
    logic [31:0]             w_tq;
    logic signed [ANG_W-1:0] w_a;

    assign w_xe = {{(XW-32){i_req.x[31]}}, i_req.x};
    assign w_ye = {{(XW-32){i_req.y[31]}}, i_req.y};
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_tq = iftf_pkg::atan_q24(5'(r_i)) >> SH;
    assign w_a  = ANG_W'(w_tq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_zero <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_zero <= (i_req.x == 32'sd0) && (i_req.y == 32'sd0);
                // pre-rotate into the right half plane
                if (i_req.x < 32'sd0) begin
                    r_x <= -w_xe;
                    r_y <= -w_ye;
                    r_z <= (i_req.y < 32'sd0) ? -K180 : K180;
                end else begin
                    r_x <= w_xe;
                    r_y <= w_ye;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_a;
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_a;
                end
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : r_z;

    `CHK_SAME(a_no_restart, i_clk, i_rst_n, r_busy, !i_req.start, "CORDIC restarted while busy")
    `CHK_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy, "CORDIC done not a single pulse")

endmodule
